[rtl/core/tcs_pkg.sv]
// ----------------------------------------------------------------------------
// tcs_pkg: shared types and constants for the triangle cull and shade block
// Widths of the edge, cross product and shading arithmetic, the beat formats
// between the front part, the queue and the back part.
// ----------------------------------------------------------------------------
package tcs_pkg;

  // Input and result field widths.
  localparam int COORD_W  = 16;
  localparam int COL_W    = 8;
  localparam int TRI_W    = 10;
  localparam int DIGIT_W  = 3;

  // Cross product arithmetic: 17-bit edges, 34-bit products, 35-bit normal.
  localparam int EDGE_W   = COORD_W + 1;
  localparam int PROD_W   = 2 * EDGE_W;
  localparam int N_W      = PROD_W + 1;
  // A normal component is below 2^33 in magnitude.
  localparam int MAG_W    = 33;

  // Base-6 digit extraction by reciprocal multiplication.
  localparam int RECIP6_MUL     = 171;
  localparam int RECIP6_SHIFT   = 10;
  localparam int RECIP6_MUL_S   = 43;
  localparam int RECIP6_SHIFT_S = 8;
  localparam int DIGIT_BASE     = 6;
  localparam int DIGIT_BASE_SQ  = 36;

  // Square root of the saturated sum of squares.
  localparam int RAD_W     = 32;
  localparam int ROOT_W    = 16;
  localparam int SQ_STEPS  = 2;
  localparam int SQ_STAGES = ROOT_W / SQ_STEPS;

  // Normalizing division: (|n| << 10) / root, one quotient bit per step.
  localparam int NORM_SHIFT = 10;
  localparam int DIV_STEPS  = 3;
  localparam int DIV_STAGES = 15;
  localparam int DIV_W      = DIV_STEPS * DIV_STAGES;
  // A normalized component stays below 2^28.
  localparam int Q_W        = 29;
  localparam int L_W        = 32;

  // Shading.
  localparam int LIGHT_BIAS  = 1200;
  localparam int LIGHT_GAIN  = 100;
  localparam int LIGHT_SHIFT = 18;
  localparam int DIGIT_MAX   = 5;
  localparam int DG_W        = 9;
  // Any light term at or above this saturates every nonzero digit.
  localparam int TC_MAX      = 16384;
  localparam int TC_W        = 15;
  localparam int SHADE_W     = DG_W + TC_W;

  // Queue between the front and back parts.
  localparam int MID_DEPTH = 8;
  localparam int MID_AW    = 3;
  localparam int MID_CW    = MID_AW + 1;

  // Beat written into the queue by the front part.
  typedef struct packed {
    logic                               culled;
    logic [COORD_W-1:0]                 depth;
    logic [2:0][DG_W-1:0]               dg;
    logic [TRI_W-1:0]                   tri_num;
    logic [2:0]                         neg;
    logic [2:0][MAG_W-1:0]              mag;
  } tri_beat_t;

  // Fields carried alongside the back part's arithmetic.
  typedef struct packed {
    logic                               culled;
    logic [COORD_W-1:0]                 depth;
    logic [2:0][DG_W-1:0]               dg;
    logic [TRI_W-1:0]                   tri_num;
    logic [2:0]                         neg;
  } side_t;

endpackage

[rtl/core/triangle_cull_and_shade_top.sv]
// ----------------------------------------------------------------------------
// triangle_cull_and_shade_top: back-face culling and flat shading
// One projected triangle in, one result out: culled flag, depth key, shaded
// colour index and triangle number.
//
//   Channel   Handshake           Beat contents
//   --------  ------------------  ----------------------------------------
//   input     push_i / full_o     three vertices, base colour, triangle no.
//   result    empty_o / pop_i     culled, depth key, shaded colour, tri no.
//
// One triangle per cycle while full_o is low and the consumer pops. A result
// passes the 8-stage square root and then the 15-stage dividers. A front
// part of three stages feeds an 8-entry queue; the back part and its
// output register stall together when the consumer does not pop, while the
// front keeps filling the queue. No clearing pass after reset.
// ----------------------------------------------------------------------------
module triangle_cull_and_shade_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  output logic                           full_o,
  input  logic [tcs_pkg::COORD_W-1:0]    ax_i,
  input  logic [tcs_pkg::COORD_W-1:0]    ay_i,
  input  logic [tcs_pkg::COORD_W-1:0]    az_i,
  input  logic [tcs_pkg::COORD_W-1:0]    bx_i,
  input  logic [tcs_pkg::COORD_W-1:0]    by_coord_i,
  input  logic [tcs_pkg::COORD_W-1:0]    bz_i,
  input  logic [tcs_pkg::COORD_W-1:0]    cx_i,
  input  logic [tcs_pkg::COORD_W-1:0]    cy_i,
  input  logic [tcs_pkg::COORD_W-1:0]    cz_i,
  input  logic [tcs_pkg::COL_W-1:0]      base_colour_i,
  input  logic [tcs_pkg::TRI_W-1:0]      tri_number_i,
  output logic                           empty_o,
  input  logic                           pop_i,
  output logic                           culled_o,
  output logic [tcs_pkg::COORD_W-1:0]    depth_key_o,
  output logic [tcs_pkg::COL_W-1:0]      shaded_colour_o,
  output logic [tcs_pkg::TRI_W-1:0]      tri_out_o
);

  logic                           wr_en;
  tcs_pkg::tri_beat_t             wr_data;
  logic                           rd_en;
  tcs_pkg::tri_beat_t             rd_data;
  logic                           mid_empty;
  logic [tcs_pkg::MID_CW-1:0]     mid_count;

  // Intake and classification.
  tcs_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push_i),
    .full_o        (full_o),
    .ax_i          (ax_i),
    .ay_i          (ay_i),
    .az_i          (az_i),
    .bx_i          (bx_i),
    .by_coord_i    (by_coord_i),
    .bz_i          (bz_i),
    .cx_i          (cx_i),
    .cy_i          (cy_i),
    .cz_i          (cz_i),
    .base_colour_i (base_colour_i),
    .tri_number_i  (tri_number_i),
    .mid_count_i   (mid_count),
    .wr_en_o       (wr_en),
    .wr_data_o     (wr_data)
  );

  // Decoupling queue.
  tcs_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_data_o (rd_data),
    .empty_o   (mid_empty),
    .count_o   (mid_count)
  );

  // Normalization and shading.
  tcs_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (rd_data),
    .mid_empty_i     (mid_empty),
    .rd_en_o         (rd_en),
    .pop_i           (pop_i),
    .empty_o         (empty_o),
    .culled_o        (culled_o),
    .depth_key_o     (depth_key_o),
    .shaded_colour_o (shaded_colour_o),
    .tri_out_o       (tri_out_o)
  );

endmodule

[rtl/core/tcs_front.sv]
// ----------------------------------------------------------------------------
// tcs_front: triangle intake and classification
// Forms the edges, the cross product and the cull decision in three stages
// and writes one beat per triangle into the queue. Entry is gated by credit.
// ----------------------------------------------------------------------------
module tcs_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push_i,
  output logic                              full_o,
  input  logic [tcs_pkg::COORD_W-1:0]       ax_i,
  input  logic [tcs_pkg::COORD_W-1:0]       ay_i,
  input  logic [tcs_pkg::COORD_W-1:0]       az_i,
  input  logic [tcs_pkg::COORD_W-1:0]       bx_i,
  input  logic [tcs_pkg::COORD_W-1:0]       by_coord_i,
  input  logic [tcs_pkg::COORD_W-1:0]       bz_i,
  input  logic [tcs_pkg::COORD_W-1:0]       cx_i,
  input  logic [tcs_pkg::COORD_W-1:0]       cy_i,
  input  logic [tcs_pkg::COORD_W-1:0]       cz_i,
  input  logic [tcs_pkg::COL_W-1:0]         base_colour_i,
  input  logic [tcs_pkg::TRI_W-1:0]         tri_number_i,
  input  logic [tcs_pkg::MID_CW-1:0]        mid_count_i,
  output logic                              wr_en_o,
  output tcs_pkg::tri_beat_t                wr_data_o
);

  logic accept;
  logic v1_q, v2_q, v3_q;

  // Stage one registers.
  logic signed [tcs_pkg::EDGE_W-1:0] e1_q [3];
  logic signed [tcs_pkg::EDGE_W-1:0] e2_q [3];
  logic [tcs_pkg::COORD_W-1:0]       depth1_q;
  logic [2:0][tcs_pkg::DIGIT_W-1:0]  dig1_q;
  logic [tcs_pkg::TRI_W-1:0]         tri1_q;

  // Stage two registers.
  logic signed [tcs_pkg::PROD_W-1:0] p_q [6];
  logic [tcs_pkg::COORD_W-1:0]       depth2_q;
  logic [2:0][tcs_pkg::DG_W-1:0]     dg2_q;
  logic [tcs_pkg::TRI_W-1:0]         tri2_q;

  // Stage three register.
  tcs_pkg::tri_beat_t                beat3_q;

  // Digit extraction signals.
  logic [15:0]                       c171;
  logic [5:0]                        q6;
  logic [11:0]                       q43;
  logic [3:0]                        q36;
  logic [7:0]                        dig_b;
  logic [5:0]                        dig_g;
  logic [3:0]                        dig_r;

  // Normal components.
  logic signed [tcs_pkg::N_W-1:0]    n [3];
  logic signed [tcs_pkg::N_W-1:0]    nabs [3];

  logic [2:0]                        inflight;
  logic [tcs_pkg::MID_CW:0]          credit_use;

  assign accept = push_i && !full_o;

  // Credit check: every triangle in flight owns a queue slot.
  assign inflight   = 3'(v1_q) + 3'(v2_q) + 3'(v3_q);
  assign credit_use = (tcs_pkg::MID_CW + 1)'(mid_count_i) + (tcs_pkg::MID_CW + 1)'(inflight);
  assign full_o     = credit_use >= (tcs_pkg::MID_CW + 1)'(tcs_pkg::MID_DEPTH);

  // Base-6 digits of the colour index through reciprocal multiplies.
  always_comb begin
    c171  = 16'(base_colour_i) * 16'(tcs_pkg::RECIP6_MUL);
    q6    = 6'(c171 >> tcs_pkg::RECIP6_SHIFT);
    dig_b = base_colour_i - 8'(q6) * 8'(tcs_pkg::DIGIT_BASE);
    q43   = 12'(q6) * 12'(tcs_pkg::RECIP6_MUL_S);
    q36   = 4'(q43 >> tcs_pkg::RECIP6_SHIFT_S);
    dig_g = q6 - 6'(q36) * 6'(tcs_pkg::DIGIT_BASE);
    dig_r = (q36 >= 4'(tcs_pkg::DIGIT_BASE)) ? q36 - 4'(tcs_pkg::DIGIT_BASE) : q36;
  end

  // Cross product differences and magnitudes.
  always_comb begin
    n[0] = tcs_pkg::N_W'(p_q[0]) - tcs_pkg::N_W'(p_q[1]);
    n[1] = tcs_pkg::N_W'(p_q[2]) - tcs_pkg::N_W'(p_q[3]);
    n[2] = tcs_pkg::N_W'(p_q[4]) - tcs_pkg::N_W'(p_q[5]);
    for (int i = 0; i < 3; i++) begin
      nabs[i] = n[i][tcs_pkg::N_W-1] ? -n[i] : n[i];
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Stage one: edges, depth key and colour digits.
  always_ff @(posedge clk_i) begin
    e1_q[0]  <= $signed({1'b0, cx_i}) - $signed({1'b0, ax_i});
    e1_q[1]  <= $signed({1'b0, cy_i}) - $signed({1'b0, ay_i});
    e1_q[2]  <= $signed({1'b0, cz_i}) - $signed({1'b0, az_i});
    e2_q[0]  <= $signed({1'b0, bx_i}) - $signed({1'b0, ax_i});
    e2_q[1]  <= $signed({1'b0, by_coord_i}) - $signed({1'b0, ay_i});
    e2_q[2]  <= $signed({1'b0, bz_i}) - $signed({1'b0, az_i});
    depth1_q <= az_i + bz_i + cz_i;
    dig1_q   <= {dig_r[2:0], dig_g[2:0], dig_b[2:0]};
    tri1_q   <= tri_number_i;
  end

  // Stage two: the six partial products and the scaled digits.
  always_ff @(posedge clk_i) begin
    p_q[0]   <= tcs_pkg::PROD_W'(e1_q[1]) * tcs_pkg::PROD_W'(e2_q[2]);
    p_q[1]   <= tcs_pkg::PROD_W'(e1_q[2]) * tcs_pkg::PROD_W'(e2_q[1]);
    p_q[2]   <= tcs_pkg::PROD_W'(e1_q[2]) * tcs_pkg::PROD_W'(e2_q[0]);
    p_q[3]   <= tcs_pkg::PROD_W'(e1_q[0]) * tcs_pkg::PROD_W'(e2_q[2]);
    p_q[4]   <= tcs_pkg::PROD_W'(e1_q[0]) * tcs_pkg::PROD_W'(e2_q[1]);
    p_q[5]   <= tcs_pkg::PROD_W'(e1_q[1]) * tcs_pkg::PROD_W'(e2_q[0]);
    depth2_q <= depth1_q;
    for (int i = 0; i < 3; i++) begin
      dg2_q[i] <= tcs_pkg::DG_W'(dig1_q[i]) * tcs_pkg::DG_W'(tcs_pkg::LIGHT_GAIN);
    end
    tri2_q   <= tri1_q;
  end

  // Stage three: normal, cull decision and queue beat.
  always_ff @(posedge clk_i) begin
    beat3_q.culled  <= n[2][tcs_pkg::N_W-1];
    beat3_q.depth   <= depth2_q;
    beat3_q.dg      <= dg2_q;
    beat3_q.tri_num <= tri2_q;
    for (int i = 0; i < 3; i++) begin
      beat3_q.neg[i] <= n[i][tcs_pkg::N_W-1];
      beat3_q.mag[i] <= nabs[i][tcs_pkg::MAG_W-1:0];
    end
  end

  assign wr_en_o   = v3_q;
  assign wr_data_o = beat3_q;

endmodule

[rtl/core/tcs_fifo.sv]
// ----------------------------------------------------------------------------
// tcs_fifo: queue between the front and back parts
// A small first-in first-out queue of triangle beats with an occupancy count.
// ----------------------------------------------------------------------------
module tcs_fifo (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        wr_en_i,
  input  tcs_pkg::tri_beat_t          wr_data_i,
  input  logic                        rd_en_i,
  output tcs_pkg::tri_beat_t          rd_data_o,
  output logic                        empty_o,
  output logic [tcs_pkg::MID_CW-1:0]  count_o
);

  tcs_pkg::tri_beat_t               entry_q [tcs_pkg::MID_DEPTH];
  logic [tcs_pkg::MID_AW-1:0]       wr_ptr_q, rd_ptr_q;
  logic [tcs_pkg::MID_CW-1:0]       count_q;

  // Pointers and occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_en_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (rd_en_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (wr_en_i && !rd_en_i) begin
        count_q <= count_q + 1'b1;
      end else if (!wr_en_i && rd_en_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      entry_q[wr_ptr_q] <= wr_data_i;
    end
  end

  assign rd_data_o = entry_q[rd_ptr_q];
  assign empty_o   = (count_q == '0);
  assign count_o   = count_q;

endmodule

[rtl/core/tcs_isqrt.sv]
// ----------------------------------------------------------------------------
// tcs_isqrt: pipelined integer square root
// Floor square root of a 32-bit value, two result bits per stage.
// ----------------------------------------------------------------------------
module tcs_isqrt (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [tcs_pkg::RAD_W-1:0]   rad_i,
  output logic [tcs_pkg::ROOT_W-1:0]  root_o
);

  logic [tcs_pkg::RAD_W-1:0]  rem_q  [tcs_pkg::SQ_STAGES];
  logic [tcs_pkg::ROOT_W-1:0] root_q [tcs_pkg::SQ_STAGES];
  logic [tcs_pkg::RAD_W-1:0]  rem_in  [tcs_pkg::SQ_STAGES];
  logic [tcs_pkg::ROOT_W-1:0] root_in [tcs_pkg::SQ_STAGES];
  logic [tcs_pkg::RAD_W-1:0]  rem_d  [tcs_pkg::SQ_STAGES];
  logic [tcs_pkg::ROOT_W-1:0] root_d [tcs_pkg::SQ_STAGES];

  for (genvar j = 0; j < tcs_pkg::SQ_STAGES; j++) begin : g_stage
    if (j == 0) begin : g_first
      assign rem_in[j]  = rad_i;
      assign root_in[j] = '0;
    end else begin : g_next
      assign rem_in[j]  = rem_q[j-1];
      assign root_in[j] = root_q[j-1];
    end

    // Trial subtraction for each result bit of this stage, highest first.
    always_comb begin
      logic [tcs_pkg::RAD_W+1:0]  t;
      logic [tcs_pkg::RAD_W-1:0]  r;
      logic [tcs_pkg::ROOT_W-1:0] g;
      int                         k;
      r = rem_in[j];
      g = root_in[j];
      for (int i = 0; i < tcs_pkg::SQ_STEPS; i++) begin
        k = tcs_pkg::ROOT_W - 1 - (j * tcs_pkg::SQ_STEPS + i);
        t = ((tcs_pkg::RAD_W + 2)'(g) << (k + 1)) + ((tcs_pkg::RAD_W + 2)'(1) << (2 * k));
        if ((tcs_pkg::RAD_W + 2)'(r) >= t) begin
          r = tcs_pkg::RAD_W'((tcs_pkg::RAD_W + 2)'(r) - t);
          g = g | (tcs_pkg::ROOT_W'(1) << k);
        end
      end
      rem_d[j]  = r;
      root_d[j] = g;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= rem_d[j];
        root_q[j] <= root_d[j];
      end
    end
  end

  assign root_o = root_q[tcs_pkg::SQ_STAGES-1];

endmodule

[rtl/core/tcs_div.sv]
// ----------------------------------------------------------------------------
// tcs_div: pipelined unsigned restoring divider
// Divides a 45-bit value by a 16-bit value, three quotient bits per stage.
// ----------------------------------------------------------------------------
module tcs_div (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [tcs_pkg::DIV_W-1:0]   dividend_i,
  input  logic [tcs_pkg::ROOT_W-1:0]  divisor_i,
  output logic [tcs_pkg::DIV_W-1:0]   quo_o
);

  localparam int REM_W = tcs_pkg::ROOT_W + 1;

  logic [REM_W-1:0]            rem_q [tcs_pkg::DIV_STAGES];
  logic [tcs_pkg::DIV_W-1:0]   num_q [tcs_pkg::DIV_STAGES];
  logic [tcs_pkg::DIV_W-1:0]   quo_q [tcs_pkg::DIV_STAGES];
  logic [tcs_pkg::ROOT_W-1:0]  dvs_q [tcs_pkg::DIV_STAGES];

  logic [REM_W-1:0]            rem_in [tcs_pkg::DIV_STAGES];
  logic [tcs_pkg::DIV_W-1:0]   num_in [tcs_pkg::DIV_STAGES];
  logic [tcs_pkg::DIV_W-1:0]   quo_in [tcs_pkg::DIV_STAGES];
  logic [tcs_pkg::ROOT_W-1:0]  dvs_in [tcs_pkg::DIV_STAGES];

  logic [REM_W-1:0]            rem_d [tcs_pkg::DIV_STAGES];
  logic [tcs_pkg::DIV_W-1:0]   num_d [tcs_pkg::DIV_STAGES];
  logic [tcs_pkg::DIV_W-1:0]   quo_d [tcs_pkg::DIV_STAGES];

  for (genvar j = 0; j < tcs_pkg::DIV_STAGES; j++) begin : g_stage
    if (j == 0) begin : g_first
      assign rem_in[j] = '0;
      assign num_in[j] = dividend_i;
      assign quo_in[j] = '0;
      assign dvs_in[j] = divisor_i;
    end else begin : g_next
      assign rem_in[j] = rem_q[j-1];
      assign num_in[j] = num_q[j-1];
      assign quo_in[j] = quo_q[j-1];
      assign dvs_in[j] = dvs_q[j-1];
    end

    // Shift in one dividend bit, subtract when the divisor fits.
    always_comb begin
      logic [REM_W-1:0]          r;
      logic [tcs_pkg::DIV_W-1:0] nm;
      logic [tcs_pkg::DIV_W-1:0] q;
      logic                      ge;
      r  = rem_in[j];
      nm = num_in[j];
      q  = quo_in[j];
      for (int i = 0; i < tcs_pkg::DIV_STEPS; i++) begin
        r  = {r[REM_W-2:0], nm[tcs_pkg::DIV_W-1]};
        nm = nm << 1;
        ge = r >= REM_W'(dvs_in[j]);
        if (ge) begin
          r = r - REM_W'(dvs_in[j]);
        end
        q = {q[tcs_pkg::DIV_W-2:0], ge};
      end
      rem_d[j] = r;
      num_d[j] = nm;
      quo_d[j] = q;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= rem_d[j];
        num_q[j] <= num_d[j];
        quo_q[j] <= quo_d[j];
        dvs_q[j] <= dvs_in[j];
      end
    end
  end

  assign quo_o = quo_q[tcs_pkg::DIV_STAGES-1];

endmodule

[rtl/core/tcs_back.sv]
// ----------------------------------------------------------------------------
// tcs_back: normal length, normalization and flat shading
// Takes beats from the queue, finds the normal's length, normalizes it, forms
// the light sum and shades the colour digits. One output register faces the
// consumer and the whole pipeline advances while it can take a beat.
// ----------------------------------------------------------------------------
module tcs_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  tcs_pkg::tri_beat_t             head_i,
  input  logic                           mid_empty_i,
  output logic                           rd_en_o,
  input  logic                           pop_i,
  output logic                           empty_o,
  output logic                           culled_o,
  output logic [tcs_pkg::COORD_W-1:0]    depth_key_o,
  output logic [tcs_pkg::COL_W-1:0]      shaded_colour_o,
  output logic [tcs_pkg::TRI_W-1:0]      tri_out_o
);

  // Register stages: three for squares, then the root, then the divider.
  localparam int MAG_LAT  = 3 + tcs_pkg::SQ_STAGES;
  localparam int SIDE_LAT = MAG_LAT + tcs_pkg::DIV_STAGES;
  localparam int VLD_LAT  = SIDE_LAT + 2;

  logic                               adv;
  logic                               vld_q  [VLD_LAT];
  tcs_pkg::side_t                     side_q [SIDE_LAT];
  logic [2:0][tcs_pkg::MAG_W-1:0]     mag_q  [MAG_LAT];
  logic                               zero_q [tcs_pkg::DIV_STAGES];

  logic [tcs_pkg::RAD_W-1:0]          sq_q [3];
  logic [2:0]                         big_q;
  logic [tcs_pkg::RAD_W-1:0]          rad_q;
  logic [tcs_pkg::RAD_W+1:0]          sq_sum;
  logic [tcs_pkg::ROOT_W-1:0]         root;
  logic [tcs_pkg::DIV_W-1:0]          quo [3];

  logic signed [tcs_pkg::L_W-1:0]     m [3];
  logic signed [tcs_pkg::L_W-1:0]     light;
  logic signed [tcs_pkg::L_W:0]       lt;
  logic [tcs_pkg::TC_W-1:0]           tc_d;
  logic [tcs_pkg::TC_W-1:0]           tc_q;
  tcs_pkg::side_t                     side27_q, side28_q;

  logic [tcs_pkg::SHADE_W-1:0]        shade [3];
  logic [tcs_pkg::SHADE_W-1:0]        shade_lvl [3];
  logic [2:0][tcs_pkg::DIGIT_W-1:0]   dig_d;
  logic [2:0][tcs_pkg::DIGIT_W-1:0]   dig_q;
  logic [tcs_pkg::COL_W-1:0]          colour;

  logic                               out_valid_q;
  logic                               out_culled_q;
  logic [tcs_pkg::COORD_W-1:0]        out_depth_q;
  logic [tcs_pkg::COL_W-1:0]          out_colour_q;
  logic [tcs_pkg::TRI_W-1:0]          out_tri_q;

  // The pipeline moves whenever the output register is free or being taken.
  assign adv     = !out_valid_q || pop_i;
  assign rd_en_o = adv && !mid_empty_i;

  // Valid bits of every stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < VLD_LAT; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else if (adv) begin
      vld_q[0] <= !mid_empty_i;
      for (int i = 1; i < VLD_LAT; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
    end
  end

  // Side fields and magnitudes ride along with the arithmetic.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0].culled  <= head_i.culled;
      side_q[0].depth   <= head_i.depth;
      side_q[0].dg      <= head_i.dg;
      side_q[0].tri_num <= head_i.tri_num;
      side_q[0].neg     <= head_i.neg;
      for (int i = 1; i < SIDE_LAT; i++) begin
        side_q[i] <= side_q[i-1];
      end
      mag_q[0] <= head_i.mag;
      for (int i = 1; i < MAG_LAT; i++) begin
        mag_q[i] <= mag_q[i-1];
      end
    end
  end

  // Squares of the low halves; a component above 16 bits saturates the sum.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        sq_q[c]  <= tcs_pkg::RAD_W'(mag_q[0][c][tcs_pkg::ROOT_W-1:0])
                    * tcs_pkg::RAD_W'(mag_q[0][c][tcs_pkg::ROOT_W-1:0]);
        big_q[c] <= |mag_q[0][c][tcs_pkg::MAG_W-1:tcs_pkg::ROOT_W];
      end
    end
  end

  // Saturating sum of squares.
  assign sq_sum = (tcs_pkg::RAD_W + 2)'(sq_q[0]) + (tcs_pkg::RAD_W + 2)'(sq_q[1])
                + (tcs_pkg::RAD_W + 2)'(sq_q[2]);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if ((|big_q) || (|sq_sum[tcs_pkg::RAD_W+1:tcs_pkg::RAD_W])) begin
        rad_q <= '1;
      end else begin
        rad_q <= sq_sum[tcs_pkg::RAD_W-1:0];
      end
    end
  end

  tcs_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (adv),
    .rad_i  (rad_q),
    .root_o (root)
  );

  // One divider per normal component.
  for (genvar c = 0; c < 3; c++) begin : g_div
    tcs_div u_div (
      .clk_i      (clk_i),
      .en_i       (adv),
      .dividend_i (tcs_pkg::DIV_W'(mag_q[MAG_LAT-1][c]) << tcs_pkg::NORM_SHIFT),
      .divisor_i  (root),
      .quo_o      (quo[c])
    );
  end

  // A zero-length normal takes no light; remember it beside the dividers.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      zero_q[0] <= (root == '0);
      for (int i = 1; i < tcs_pkg::DIV_STAGES; i++) begin
        zero_q[i] <= zero_q[i-1];
      end
    end
  end

  // Light sum x - y + z, biased and limited to the useful range.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      m[c] = $signed(tcs_pkg::L_W'(quo[c][tcs_pkg::Q_W-1:0]));
      if (side_q[SIDE_LAT-1].neg[c]) begin
        m[c] = -m[c];
      end
    end
    light = zero_q[tcs_pkg::DIV_STAGES-1] ? '0 : (m[0] - m[1] + m[2]);
    lt    = (tcs_pkg::L_W + 1)'(light) + (tcs_pkg::L_W + 1)'(tcs_pkg::LIGHT_BIAS);
    if (lt <= 0) begin
      tc_d = '0;
    end else if (lt > (tcs_pkg::L_W + 1)'(tcs_pkg::TC_MAX)) begin
      tc_d = tcs_pkg::TC_W'(tcs_pkg::TC_MAX);
    end else begin
      tc_d = lt[tcs_pkg::TC_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tc_q     <= tc_d;
      side27_q <= side_q[SIDE_LAT-1];
    end
  end

  // Scale each digit by the light term, then clamp to a base-6 digit.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      shade[c]     = tcs_pkg::SHADE_W'(side27_q.dg[c]) * tcs_pkg::SHADE_W'(tc_q);
      shade_lvl[c] = shade[c] >> tcs_pkg::LIGHT_SHIFT;
      if (shade_lvl[c] > tcs_pkg::SHADE_W'(tcs_pkg::DIGIT_MAX)) begin
        dig_d[c] = tcs_pkg::DIGIT_W'(tcs_pkg::DIGIT_MAX);
      end else begin
        dig_d[c] = shade_lvl[c][tcs_pkg::DIGIT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dig_q    <= dig_d;
      side28_q <= side27_q;
    end
  end

  // Recombine the digits into a colour index.
  assign colour = tcs_pkg::COL_W'(dig_q[2]) * tcs_pkg::COL_W'(tcs_pkg::DIGIT_BASE_SQ)
                + tcs_pkg::COL_W'(dig_q[1]) * tcs_pkg::COL_W'(tcs_pkg::DIGIT_BASE)
                + tcs_pkg::COL_W'(dig_q[0]);

  // Output register; a culled triangle reports zero fields.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= vld_q[VLD_LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_culled_q <= side28_q.culled;
      out_depth_q  <= side28_q.culled ? '0 : side28_q.depth;
      out_colour_q <= side28_q.culled ? '0 : colour;
      out_tri_q    <= side28_q.culled ? '0 : side28_q.tri_num;
    end
  end

  assign empty_o         = !out_valid_q;
  assign culled_o        = out_culled_q;
  assign depth_key_o     = out_depth_q;
  assign shaded_colour_o = out_colour_q;
  assign tri_out_o       = out_tri_q;

endmodule

[rtl/core/tcs_checker.sv]
// ----------------------------------------------------------------------------
// tcs_checker: port-level checks for the triangle cull and shade block
// Watches the top level's ports and flags results that break the block's
// rules for culled beats, colour range and the result handshake.
// ----------------------------------------------------------------------------
module tcs_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  input  logic                           full_o,
  input  logic [tcs_pkg::COORD_W-1:0]    ax_i,
  input  logic [tcs_pkg::COORD_W-1:0]    ay_i,
  input  logic [tcs_pkg::COORD_W-1:0]    az_i,
  input  logic [tcs_pkg::COORD_W-1:0]    bx_i,
  input  logic [tcs_pkg::COORD_W-1:0]    by_coord_i,
  input  logic [tcs_pkg::COORD_W-1:0]    bz_i,
  input  logic [tcs_pkg::COORD_W-1:0]    cx_i,
  input  logic [tcs_pkg::COORD_W-1:0]    cy_i,
  input  logic [tcs_pkg::COORD_W-1:0]    cz_i,
  input  logic [tcs_pkg::COL_W-1:0]      base_colour_i,
  input  logic [tcs_pkg::TRI_W-1:0]      tri_number_i,
  input  logic                           empty_o,
  input  logic                           pop_i,
  input  logic                           culled_o,
  input  logic [tcs_pkg::COORD_W-1:0]    depth_key_o,
  input  logic [tcs_pkg::COL_W-1:0]      shaded_colour_o,
  input  logic [tcs_pkg::TRI_W-1:0]      tri_out_o
);

  // A culled beat carries no depth, colour or triangle number.
  a_culled_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && culled_o) |->
      (depth_key_o == '0) && (shaded_colour_o == '0) && (tri_out_o == '0))
    else $error("culled result with nonzero fields");

  // Shaded digits stay within base 6.
  a_colour_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o |-> (shaded_colour_o <= tcs_pkg::COL_W'(215)))
    else $error("shaded colour out of range");

  // No result can be ready right after reset is released.
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> empty_o)
    else $error("result present just after reset");

  // A waiting result holds until it is popped.
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !pop_i) |=> (!empty_o && $stable(culled_o) && $stable(depth_key_o)
      && $stable(shaded_colour_o) && $stable(tri_out_o)))
    else $error("waiting result changed before pop");

endmodule

bind triangle_cull_and_shade_top tcs_checker u_tcs_checker (.*);

[tb/sv/tcs_checker.sv]
// ----------------------------------------------------------------------------
// tcs_result_checker: result checker for the triangle cull and shade block
// Watches the input and result channels, predicts each result from the
// accepted triangle, and compares every popped beat field by field.
// ----------------------------------------------------------------------------
module tcs_result_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  logic                        full_i,
  input  logic [tcs_pkg::COORD_W-1:0] ax_i,
  input  logic [tcs_pkg::COORD_W-1:0] ay_i,
  input  logic [tcs_pkg::COORD_W-1:0] az_i,
  input  logic [tcs_pkg::COORD_W-1:0] bx_i,
  input  logic [tcs_pkg::COORD_W-1:0] by_coord_i,
  input  logic [tcs_pkg::COORD_W-1:0] bz_i,
  input  logic [tcs_pkg::COORD_W-1:0] cx_i,
  input  logic [tcs_pkg::COORD_W-1:0] cy_i,
  input  logic [tcs_pkg::COORD_W-1:0] cz_i,
  input  logic [tcs_pkg::COL_W-1:0]   base_colour_i,
  input  logic [tcs_pkg::TRI_W-1:0]   tri_number_i,
  input  logic                        empty_i,
  input  logic                        pop_i,
  input  logic                        culled_i,
  input  logic [tcs_pkg::COORD_W-1:0] depth_key_i,
  input  logic [tcs_pkg::COL_W-1:0]   shaded_colour_i,
  input  logic [tcs_pkg::TRI_W-1:0]   tri_out_i,
  output int                          errors_o,
  output int                          outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic                        culled;
    logic [tcs_pkg::COORD_W-1:0] depth;
    logic [tcs_pkg::COL_W-1:0]   colour;
    logic [tcs_pkg::TRI_W-1:0]   tri_num;
  } shade_res_t;

  shade_res_t expected_shades[$];

  // Bitwise integer square root over 16 result bits.
  function automatic longint unsigned root16(longint unsigned v);
    longint unsigned g, bitv, t;
    int sh;
    g = 0;
    bitv = 64'h8000;
    sh = 15;
    while (bitv != 0) begin
      t = ((g << 1) + bitv) << sh;
      if (v >= t) begin
        g += bitv;
        v -= t;
      end
      bitv >>= 1;
      if (sh > 0) sh--;
    end
    return g;
  endfunction

  // One base-6 digit scaled by the light sum, floored and clamped to 0..5.
  function automatic longint shade_one(longint d, longint light);
    longint v;
    v = (d * (light + tcs_pkg::LIGHT_BIAS) * tcs_pkg::LIGHT_GAIN) >>> tcs_pkg::LIGHT_SHIFT;
    if (v < 0) v = 0;
    if (v > tcs_pkg::DIGIT_MAX) v = tcs_pkg::DIGIT_MAX;
    return v;
  endfunction

  // Cross product, culling test, normalization and flat shade of one triangle.
  function automatic shade_res_t cull_and_shade(
    input longint a[3], input longint b[3], input longint c[3],
    input longint col, input logic [tcs_pkg::TRI_W-1:0] tri_num
  );
    shade_res_t res;
    longint e1[3], e2[3], n[3], m[3], light;
    longint unsigned mag, acc, root;
    logic sat;
    for (int i = 0; i < 3; i++) begin
      e1[i] = c[i] - a[i];
      e2[i] = b[i] - a[i];
    end
    n[0] = e1[1] * e2[2] - e1[2] * e2[1];
    n[1] = e1[2] * e2[0] - e1[0] * e2[2];
    n[2] = e1[0] * e2[1] - e1[1] * e2[0];
    res = '{culled: 1'b0, depth: '0, colour: '0, tri_num: '0};
    if (n[2] < 0) begin
      res.culled = 1'b1;
      return res;
    end
    // Saturating sum of squares, then the root.
    acc = 0;
    sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      mag = (n[i] < 0) ? -n[i] : n[i];
      if (mag > 64'hFFFF) sat = 1'b1;
      else acc += mag * mag;
    end
    if (sat || acc > 64'hFFFF_FFFF) acc = 64'hFFFF_FFFF;
    root = root16(acc);
    light = 0;
    // A zero-length normal leaves the light sum at zero.
    if (root != 0) begin
      for (int i = 0; i < 3; i++) m[i] = (1024 * n[i]) / longint'(root);
      light = m[0] - m[1] + m[2];
    end
    res.depth  = tcs_pkg::COORD_W'(a[2] + b[2] + c[2]);
    res.colour = tcs_pkg::COL_W'(
        shade_one((col / tcs_pkg::DIGIT_BASE_SQ) % tcs_pkg::DIGIT_BASE, light)
          * tcs_pkg::DIGIT_BASE_SQ
      + shade_one((col / tcs_pkg::DIGIT_BASE) % tcs_pkg::DIGIT_BASE, light)
          * tcs_pkg::DIGIT_BASE
      + shade_one(col % tcs_pkg::DIGIT_BASE, light));
    res.tri_num = tri_num;
    return res;
  endfunction

  // Inputs change only at rising edges, so the falling edge sees the beats
  // that the next rising edge will accept.
  always @(negedge clk_i) begin
    shade_res_t want;
    longint a[3], b[3], c[3];
    if (!rst_ni) begin
      errors_o      = 0;
      outstanding_o = 0;
    end else begin
      if (pop_i && !empty_i) begin
        if (expected_shades.size() == 0) begin
          $display("%0t: result beat with nothing expected: culled %0b depth %0h colour %0d tri %0d",
                   $time, culled_i, depth_key_i, shaded_colour_i, tri_out_i);
          errors_o++;
        end else begin
          want = expected_shades.pop_front();
          if (culled_i !== want.culled) begin
            $display("%0t: culled expected %0b actual %0b", $time, want.culled, culled_i);
            errors_o++;
          end
          if (depth_key_i !== want.depth) begin
            $display("%0t: depth_key expected %0h actual %0h", $time, want.depth, depth_key_i);
            errors_o++;
          end
          if (shaded_colour_i !== want.colour) begin
            $display("%0t: shaded_colour expected %0d actual %0d", $time, want.colour,
                     shaded_colour_i);
            errors_o++;
          end
          if (tri_out_i !== want.tri_num) begin
            $display("%0t: tri_out expected %0d actual %0d", $time, want.tri_num, tri_out_i);
            errors_o++;
          end
        end
      end
      if (push_i && !full_i) begin
        a = '{longint'(ax_i), longint'(ay_i), longint'(az_i)};
        b = '{longint'(bx_i), longint'(by_coord_i), longint'(bz_i)};
        c = '{longint'(cx_i), longint'(cy_i), longint'(cz_i)};
        expected_shades.push_back(cull_and_shade(a, b, c, longint'(base_colour_i),
                                                 tri_number_i));
      end
      outstanding_o = expected_shades.size();
    end
  end

endmodule

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: testbench for triangle_cull_and_shade_top
// Sends directed and random triangles with random idle bursts on both sides,
// a long receiver hold-off and a full drain, and reports the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_TRIS = 1280;
  localparam int QUIET_FROM  = 1100;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        push_i = 1'b0;
  logic                        pop_i = 1'b0;
  logic                        full_o, empty_o, culled_o;
  logic [tcs_pkg::COORD_W-1:0] ax_i = '0, ay_i = '0, az_i = '0;
  logic [tcs_pkg::COORD_W-1:0] bx_i = '0, by_coord_i = '0, bz_i = '0;
  logic [tcs_pkg::COORD_W-1:0] cx_i = '0, cy_i = '0, cz_i = '0;
  logic [tcs_pkg::COL_W-1:0]   base_colour_i = '0;
  logic [tcs_pkg::TRI_W-1:0]   tri_number_i = '0;
  logic [tcs_pkg::COORD_W-1:0] depth_key_o;
  logic [tcs_pkg::COL_W-1:0]   shaded_colour_o;
  logic [tcs_pkg::TRI_W-1:0]   tri_out_o;
  int                          errors, outstanding;
  bit                          quiet = 1'b0;
  bit                          long_hold = 1'b0;

  triangle_cull_and_shade_top DUT (.*);

  tcs_result_checker u_checker (
    .clk_i, .rst_ni, .push_i, .full_i(full_o),
    .ax_i, .ay_i, .az_i, .bx_i, .by_coord_i, .bz_i, .cx_i, .cy_i, .cz_i,
    .base_colour_i, .tri_number_i, .empty_i(empty_o), .pop_i,
    .culled_i(culled_o), .depth_key_i(depth_key_o), .shaded_colour_i(shaded_colour_o),
    .tri_out_i(tri_out_o), .errors_o(errors), .outstanding_o(outstanding)
  );

  // Clock, 8 ns period.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Offer one triangle beat and hold it until it is accepted.
  task automatic send_tri(input logic [tcs_pkg::COORD_W-1:0] v[9],
                          input logic [tcs_pkg::COL_W-1:0] col,
                          input logic [tcs_pkg::TRI_W-1:0] tri_num);
    push_i        <= 1'b1;
    ax_i          <= v[0];
    ay_i          <= v[1];
    az_i          <= v[2];
    bx_i          <= v[3];
    by_coord_i    <= v[4];
    bz_i          <= v[5];
    cx_i          <= v[6];
    cy_i          <= v[7];
    cz_i          <= v[8];
    base_colour_i <= col;
    tri_number_i  <= tri_num;
    forever begin
      @(negedge clk_i);
      if (!full_o) break;
    end
    @(posedge clk_i);
  endtask

  // Sender idle burst between beats.
  task automatic maybe_idle();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      push_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
  endtask

  // Receiver: random stall bursts, one long hold-off on request.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        pop_i <= 1'b0;
        repeat (300) @(posedge clk_i);
        long_hold = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        pop_i <= 1'b0;
        repeat ($urandom_range(1, 11) - 1) @(posedge clk_i);
      end else begin
        pop_i <= 1'b1;
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    logic [tcs_pkg::COORD_W-1:0] v[9];
    logic [tcs_pkg::COORD_W-1:0] base;
    int span;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: degenerate, extreme, culled, saturated and odd colour cases.
    v = '{default: '0};
    send_tri(v, 8'd0, 10'd0);
    v = '{default: 16'hFFFF};
    send_tri(v, 8'd215, 10'd1023);
    v = '{0, 0, 0, 16'hFFFF, 0, 0, 0, 16'hFFFF, 0};
    send_tri(v, 8'd215, 10'd1);
    v = '{0, 0, 0, 0, 16'hFFFF, 0, 16'hFFFF, 0, 0};
    send_tri(v, 8'd215, 10'd2);
    v = '{0, 0, 0, 16'hFFFF, 0, 16'hFFFF, 0, 16'hFFFF, 16'hFFFF};
    send_tri(v, 8'd255, 10'd3);
    v = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 16'hFFFF, 0, 16'hFFFF, 0, 0};
    send_tri(v, 8'd216, 10'd4);
    v = '{0, 0, 100, 10, 0, 100, 0, 10, 100};
    send_tri(v, 8'd215, 10'd5);
    v = '{0, 0, 100, 0, 10, 100, 10, 0, 100};
    send_tri(v, 8'd215, 10'd6);
    v = '{0, 0, 0, 10, 0, 0, 0, 10, 0};
    send_tri(v, 8'd43, 10'd7);
    v = '{0, 0, 0, 10, 0, 5, 0, 10, 7};
    send_tri(v, 8'd129, 10'd8);
    v = '{0, 0, 0, 10, 0, 16'hFFFF, 0, 10, 16'hFFFF};
    send_tri(v, 8'd100, 10'd9);
    v = '{5, 5, 5, 10, 10, 10, 15, 15, 15};
    send_tri(v, 8'd180, 10'd10);
    v = '{100, 200, 300, 100, 200, 300, 40, 50, 60};
    send_tri(v, 8'd35, 10'd11);
    v = '{0, 0, 0, 1, 0, 0, 0, 1, 0};
    send_tri(v, 8'd215, 10'd12);
    v = '{0, 0, 16'h8000, 3, 0, 16'h8000, 0, 3, 16'h8001};
    send_tri(v, 8'd1, 10'd13);
    v = '{1000, 1000, 0, 1001, 1000, 0, 1000, 1001, 0};
    send_tri(v, 8'd6, 10'd512);
    v = '{0, 0, 0, 16'hFFFF, 1, 0, 1, 16'hFFFF, 0};
    send_tri(v, 8'd254, 10'd14);

    // Random: full-range, small local triangles and degenerate ones.
    for (int k = 0; k < RANDOM_TRIS; k++) begin
      if (k == 300) long_hold = 1'b1;
      if (k == 700) begin
        push_i <= 1'b0;
        wait (outstanding == 0);
        @(posedge clk_i);
      end
      if (k == QUIET_FROM) quiet = 1'b1;
      case ($urandom_range(0, 9)) inside
        0, 1, 2: begin
          for (int i = 0; i < 9; i++) v[i] = tcs_pkg::COORD_W'($urandom);
        end
        9: begin
          for (int i = 0; i < 3; i++) v[i] = tcs_pkg::COORD_W'($urandom);
          for (int i = 3; i < 9; i++) begin
            v[i] = tcs_pkg::COORD_W'(v[i % 3] + $urandom_range(0, 1) * i);
          end
        end
        default: begin
          span = 1 << $urandom_range(1, 12);
          for (int i = 0; i < 9; i++) begin
            base = (i < 3) ? tcs_pkg::COORD_W'($urandom) : v[i % 3];
            v[i] = (i < 3) ? base
                           : tcs_pkg::COORD_W'(base + $urandom_range(0, span) - span / 2);
          end
        end
      endcase
      send_tri(v, ($urandom_range(0, 15) == 0) ? 8'($urandom_range(216, 255))
                                               : 8'($urandom_range(0, 215)),
               10'($urandom));
      maybe_idle();
    end
    push_i <= 1'b0;

    wait (outstanding == 0);
    repeat (60) @(posedge clk_i);
    if (errors == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end

endmodule
